/* src/dlp_pkg.sv */
// Shared types and constants for the longest-route block.
// Depends on nothing; used by dlp_ctrl, dlp_datapath and dag_longest_path.
`default_nettype none
package dlp_pkg;

  localparam int NODE_W = 6;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 6'd32;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  localparam logic [1:0] KIND_LEN  = 2'd0;
  localparam logic [1:0] KIND_NODE = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;
  localparam logic [1:0] KIND_FULL = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FULL,
    ST_SEED,
    ST_POP,
    ST_PRED,
    ST_SUCC,
    ST_TRACE,
    ST_LEN,
    ST_NODE,
    ST_NONE,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic       store;
    logic       seed_start;
    logic       seed_step;
    logic       pop;
    logic       scan_start;
    logic       scan_step;
    logic       scan_pass2;
    logic       trace_start;
    logic       trace_step;
    logic       emit;
    logic [1:0] kind;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic load_ok;
    logic table_full;
    logic seed_done;
    logic q_empty;
    logic scan_done;
    logic dest_reached;
    logic trace_done;
    logic node_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* src/dlp_datapath.sv */
// Datapath: edge table, in-degree counts, Kahn queue, route tables, output register.
// Depends on dlp_pkg; driven by dlp_ctrl through cmd_t / status_t.
`default_nettype none
module dlp_datapath #(
  parameter int MAX_NODES = 32,
  parameter int MAX_EDGES = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dlp_pkg::cmd_t               cmd_i,
  output      dlp_pkg::status_t            status_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [dlp_pkg::NODE_W-1:0]  cfg_wdata_i,
  input  wire logic [dlp_pkg::NODE_W-1:0]  from_node_i,
  input  wire logic [dlp_pkg::NODE_W-1:0]  to_node_i,
  input  wire logic                        out_stall_i,
  output      logic                        out_valid_o,
  output      logic [1:0]                  kind_o,
  output      logic [dlp_pkg::NODE_W-1:0]  value_o,
  output      logic                        last_o
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int VW  = dlp_pkg::NODE_W;
  localparam logic [VW-1:0] NMAX = VW'(MAX_NODES);

  logic [VW-1:0]     node_count_q, n_eff;
  logic [NW-1:0]     dest, from_idx, to_idx;

  logic [2*NW-1:0]   edge_mem [MAX_EDGES];
  logic [2*NW-1:0]   rd_q;
  logic [ECW-1:0]    edges_q, e_q;
  logic              rvld_q, rd_en;
  logic [NW-1:0]     ex, ey;

  logic [ECW-1:0]    indeg_q [MAX_NODES];
  logic [NW-1:0]     deg_addr;
  logic [ECW-1:0]    deg_rd;

  logic [CW-1:0]     best_q [MAX_NODES];
  logic [VW-1:0]     pred_q [MAX_NODES];
  logic [MAX_NODES-1:0] touch_q;
  logic [NW-1:0]     best_addr, tidx;
  logic [CW-1:0]     best_rd, best_inc;
  logic [VW-1:0]     pred_rd;

  logic [NW-1:0]     queue_q [MAX_NODES];
  logic [CW-1:0]     head_q, tail_q, i_q;
  logic              q_empty, enq;
  logic [NW-1:0]     enq_node, q_head;

  logic [NW-1:0]     cur_q;
  logic [CW-1:0]     cur_best_q;
  logic              p1_hit, p2_hit;

  logic [VW-1:0]     stack_q [MAX_NODES];
  logic [VW-1:0]     tcur_q;
  logic [CW-1:0]     depth_q;
  logic              trace_done;

  logic              out_valid_q, out_free;
  logic [1:0]        kind_q;
  logic [VW-1:0]     value_q, value_d;
  logic              last_q, last_d;

  // node count clamp
  always_comb begin
    if (node_count_q == '0) begin
      n_eff = VW'(1);
    end else if (node_count_q > NMAX) begin
      n_eff = NMAX;
    end else begin
      n_eff = node_count_q;
    end
  end

  assign dest     = NW'(n_eff - VW'(1));
  assign from_idx = NW'(from_node_i - VW'(1));
  assign to_idx   = NW'(to_node_i - VW'(1));

  // edge table
  assign rd_en = cmd_i.scan_step && (e_q != edges_q);
  assign ex    = rd_q[2*NW-1:NW];
  assign ey    = rd_q[NW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      edge_mem[edges_q[AW-1:0]] <= {from_idx, to_idx};
    end
    if (rd_en) begin
      rd_q <= edge_mem[e_q[AW-1:0]];
    end
  end

  // shared read ports
  assign q_empty   = (head_q == tail_q);
  assign q_head    = queue_q[head_q[NW-1:0]];
  assign best_addr = rvld_q ? ex : (q_empty ? dest : q_head);
  assign best_rd   = touch_q[best_addr] ? best_q[best_addr]
                                        : ((best_addr == '0) ? CW'(1) : '0);
  assign best_inc  = CW'(best_rd + CW'(1));
  assign deg_addr  = rvld_q ? ey : (cmd_i.seed_step ? i_q[NW-1:0] : to_idx);
  assign deg_rd    = indeg_q[deg_addr];
  assign tidx      = NW'(tcur_q - VW'(1));
  assign pred_rd   = touch_q[tidx] ? pred_q[tidx] : '0;

  assign p1_hit = rvld_q && !cmd_i.scan_pass2 && (ey == cur_q) && (best_rd != '0)
                  && ({1'b0, cur_best_q} < ({1'b0, best_rd} + (CW+1)'(1)));
  assign p2_hit = rvld_q && cmd_i.scan_pass2 && (ex == cur_q) && (deg_rd != '0);

  always_comb begin
    enq      = 1'b0;
    enq_node = i_q[NW-1:0];
    if (cmd_i.seed_step && (VW'(i_q) != n_eff) && (deg_rd == '0)) begin
      enq = 1'b1;
    end
    if (p2_hit && (deg_rd == ECW'(1)) && (VW'(ey) < n_eff)) begin
      enq      = 1'b1;
      enq_node = ey;
    end
  end

  assign trace_done = (tcur_q == '0) || (depth_q == CW'(MAX_NODES));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= dlp_pkg::NODE_COUNT_RST;
      edges_q      <= '0;
      e_q          <= '0;
      rvld_q       <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
      i_q          <= '0;
      touch_q      <= '0;
      depth_q      <= '0;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < MAX_NODES; k++) begin
        indeg_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (cmd_i.store) begin
        edges_q           <= ECW'(edges_q + ECW'(1));
        indeg_q[deg_addr] <= ECW'(deg_rd + ECW'(1));
      end
      if (p2_hit) begin
        indeg_q[deg_addr] <= ECW'(deg_rd - ECW'(1));
      end
      if (cmd_i.clear) begin
        edges_q <= '0;
        for (int k = 0; k < MAX_NODES; k++) begin
          indeg_q[k] <= '0;
        end
      end
      if (cmd_i.scan_start) begin
        e_q    <= '0;
        rvld_q <= 1'b0;
      end else begin
        rvld_q <= rd_en;
        if (rd_en) begin
          e_q <= ECW'(e_q + ECW'(1));
        end
      end
      if (cmd_i.seed_start) begin
        head_q  <= '0;
        tail_q  <= '0;
        i_q     <= '0;
        touch_q <= '0;
      end else begin
        if (cmd_i.seed_step && (VW'(i_q) != n_eff)) begin
          i_q <= CW'(i_q + CW'(1));
        end
        if (enq) begin
          tail_q <= CW'(tail_q + CW'(1));
        end
        if (cmd_i.pop) begin
          head_q <= CW'(head_q + CW'(1));
        end
        if (p1_hit) begin
          touch_q[cur_q] <= 1'b1;
        end
      end
      if (cmd_i.trace_start) begin
        depth_q <= '0;
      end else if (cmd_i.trace_step && !trace_done) begin
        depth_q <= CW'(depth_q + CW'(1));
      end else if (cmd_i.emit && (cmd_i.kind == dlp_pkg::KIND_NODE)) begin
        depth_q <= CW'(depth_q - CW'(1));
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (enq) begin
      queue_q[tail_q[NW-1:0]] <= enq_node;
    end
    if (cmd_i.pop) begin
      cur_q      <= q_head;
      cur_best_q <= best_rd;
    end
    if (p1_hit) begin
      cur_best_q     <= best_inc;
      best_q[cur_q]  <= best_inc;
      pred_q[cur_q]  <= VW'(ex) + VW'(1);
    end
    if (cmd_i.trace_start) begin
      tcur_q <= VW'(dest) + VW'(1);
    end else if (cmd_i.trace_step && !trace_done) begin
      stack_q[depth_q[NW-1:0]] <= tcur_q;
      tcur_q                   <= pred_rd;
    end
    if (cmd_i.emit) begin
      kind_q  <= cmd_i.kind;
      value_q <= value_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    case (cmd_i.kind)
      dlp_pkg::KIND_LEN: begin
        value_d = VW'(depth_q);
        last_d  = 1'b0;
      end
      dlp_pkg::KIND_NODE: begin
        value_d = stack_q[NW'(depth_q - CW'(1))];
        last_d  = (depth_q == CW'(1));
      end
      default: begin
        value_d = '0;
        last_d  = 1'b1;
      end
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.load_ok      = (from_node_i != '0) && (from_node_i <= NMAX)
                                 && (to_node_i != '0) && (to_node_i <= NMAX);
  assign status_o.table_full   = (edges_q == ECW'(MAX_EDGES));
  assign status_o.seed_done    = (VW'(i_q) == n_eff);
  assign status_o.q_empty      = q_empty;
  assign status_o.scan_done    = (e_q == edges_q) && !rvld_q;
  assign status_o.dest_reached = (best_rd != '0);
  assign status_o.trace_done   = trace_done;
  assign status_o.node_last    = (depth_q == CW'(1));
  assign status_o.out_free     = out_free;

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

/* src/dlp_ctrl.sv */
// Controller state machine: sequences loads, Kahn passes, trace-back and emission.
// Depends on dlp_pkg; commands dlp_datapath.
`default_nettype none
module dlp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             mode_i,
  output      logic             in_stall_o,
  input  wire dlp_pkg::status_t status_i,
  output      dlp_pkg::cmd_t    cmd_o
);

  dlp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.kind = dlp_pkg::KIND_LEN;
    in_stall_o = (state_q != dlp_pkg::ST_IDLE);
    case (state_q)
      dlp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == dlp_pkg::MODE_RUN) begin
            cmd_o.seed_start = 1'b1;
            state_d          = dlp_pkg::ST_SEED;
          end else if (status_i.load_ok) begin
            if (status_i.table_full) begin
              state_d = dlp_pkg::ST_FULL;
            end else begin
              cmd_o.store = 1'b1;
            end
          end
        end
      end
      dlp_pkg::ST_FULL: begin
        cmd_o.kind = dlp_pkg::KIND_FULL;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = dlp_pkg::ST_IDLE;
        end
      end
      dlp_pkg::ST_SEED: begin
        cmd_o.seed_step = 1'b1;
        if (status_i.seed_done) begin
          state_d = dlp_pkg::ST_POP;
        end
      end
      dlp_pkg::ST_POP: begin
        if (!status_i.q_empty) begin
          cmd_o.pop        = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = dlp_pkg::ST_PRED;
        end else if (status_i.dest_reached) begin
          cmd_o.trace_start = 1'b1;
          state_d           = dlp_pkg::ST_TRACE;
        end else begin
          state_d = dlp_pkg::ST_NONE;
        end
      end
      dlp_pkg::ST_PRED: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          cmd_o.scan_start = 1'b1;
          state_d          = dlp_pkg::ST_SUCC;
        end
      end
      dlp_pkg::ST_SUCC: begin
        cmd_o.scan_step  = 1'b1;
        cmd_o.scan_pass2 = 1'b1;
        if (status_i.scan_done) begin
          state_d = dlp_pkg::ST_POP;
        end
      end
      dlp_pkg::ST_TRACE: begin
        cmd_o.trace_step = 1'b1;
        if (status_i.trace_done) begin
          state_d = dlp_pkg::ST_LEN;
        end
      end
      dlp_pkg::ST_LEN: begin
        cmd_o.kind = dlp_pkg::KIND_LEN;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = dlp_pkg::ST_NODE;
        end
      end
      dlp_pkg::ST_NODE: begin
        cmd_o.kind = dlp_pkg::KIND_NODE;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.node_last) begin
            state_d = dlp_pkg::ST_CLEAR;
          end
        end
      end
      dlp_pkg::ST_NONE: begin
        cmd_o.kind = dlp_pkg::KIND_NONE;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = dlp_pkg::ST_CLEAR;
        end
      end
      dlp_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = dlp_pkg::ST_IDLE;
      end
      default: begin
        state_d = dlp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/dag_longest_path.sv */
// Top level of the longest-route block: controller plus datapath, with checks.
// Depends on dlp_pkg, dlp_ctrl and dlp_datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------
//  in       | in_valid_i / in_stall_o | mode_i, from_node_i, to_node_i
//  out      | out_valid_o/ out_stall_i| kind_o, value_o, last_o
//  cfg      | cfg_we_i                | cfg_wdata_i (node_count)
//
// Edge loads transfer back to back while the block is idle.
// A load dropped on a full table stalls the input until the full report is emitted.
// A run seeds the Kahn queue with the nodes of in-degree zero, then per taken node
// pops it and makes two passes over the edge table (predecessors, then successors;
// one edge-table read per cycle), tests whether the destination was reached, traces
// the route back, emits the length and route nodes as output stalls allow, then
// clears the table and counts. Unreachable: one result, then the clear.
// Reset (async, active low) empties the edge table and in-degree counts.
// Output stall holds the output register and the emission waiting on it; a result
// waiting there does not block the next load transfer.
`default_nettype none
module dag_longest_path #(
  parameter int MAX_NODES = 32,
  parameter int MAX_EDGES = 256
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [dlp_pkg::NODE_W-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic                       mode_i,
  input  wire logic [dlp_pkg::NODE_W-1:0] from_node_i,
  input  wire logic [dlp_pkg::NODE_W-1:0] to_node_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic [1:0]                 kind_o,
  output      logic [dlp_pkg::NODE_W-1:0] value_o,
  output      logic                       last_o
);

  dlp_pkg::cmd_t    cmd;
  dlp_pkg::status_t status;

  dlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dlp_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .from_node_i (from_node_i),
    .to_node_i   (to_node_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

  // a run transfer locks the input side
  a_run_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (mode_i == dlp_pkg::MODE_RUN)) |=> in_stall_o)
    else $error("input not stalled after run transfer");

  a_node_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == dlp_pkg::KIND_NODE)) |-> (value_o != '0))
    else $error("route node of zero");

  a_single_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((kind_o == dlp_pkg::KIND_NONE) || (kind_o == dlp_pkg::KIND_FULL)))
    |-> (last_o && (value_o == '0)))
    else $error("bad impossible/full result");

  a_len_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == dlp_pkg::KIND_LEN)) |-> (!last_o && (value_o != '0)))
    else $error("bad route length result");

endmodule
`default_nettype wire

/* test/dag_longest_path_tb.sv */
// Testbench for dag_longest_path: directed graphs are loaded edge by edge,
// then searched; each route result is checked against an in-bench predictor.
// Depends on dlp_pkg and the dag_longest_path RTL.
`timescale 1ns / 100ps
`default_nettype none
module dag_longest_path_tb;

  localparam int VW = dlp_pkg::NODE_W;
  localparam int NODES_MAX = 32;
  localparam int EDGES_MAX = 256;
  localparam int ITEM_GOAL = 450;
  localparam int SETTLE_CYC = 300;  // margin after the last owed result

  typedef struct packed {
    logic [1:0]    kind;
    logic [VW-1:0] value;
    logic          last;
  } route_res_t;

  // one directed step: either a node_count write (value in a) or a transfer
  typedef struct packed {
    bit            is_cfg;
    bit            m;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    bit            typed;
    route_res_t    tr;
  } dir_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we = 1'b0;
  logic [VW-1:0] cfg_wdata = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          mode = dlp_pkg::MODE_LOAD;
  logic [VW-1:0] from_n = '0;
  logic [VW-1:0] to_n = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    kind;
  logic [VW-1:0] value;
  logic          last;

  dag_longest_path dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (mode),
    .from_node_i (from_n),
    .to_node_i   (to_n),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .value_o     (value),
    .last_o      (last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the graph store and the node_count register.
  logic [4:0]    edge_src [EDGES_MAX];
  logic [4:0]    edge_dst [EDGES_MAX];
  int            edge_cnt;
  int            in_deg [NODES_MAX];
  logic [VW-1:0] node_cnt_reg;

  route_res_t fresh_q[$];       // results of the transfer just accepted
  route_res_t route_expect_q[$]; // results still owed by the block

  int items_sent, results_seen, mismatches, runs_sent, full_seen, none_seen;
  int burst_left;
  bit long_hold_done, hold_req;
  int hold_left, pat_cyc, stall_pct;

  task automatic add_fresh(logic [1:0] k, logic [VW-1:0] v, logic l);
    route_res_t r;
    r.kind  = k;
    r.value = v;
    r.last  = l;
    fresh_q.insert(fresh_q.size(), r);
  endtask

  // Longest route prediction for one transfer; fills fresh_q.
  task automatic predict_route(bit m, logic [VW-1:0] a, logic [VW-1:0] b);
    int n, head, tail, cur, x, y, depth, c;
    int blen [NODES_MAX];
    int pred [NODES_MAX];
    int rq [NODES_MAX];
    int stk [NODES_MAX];
    fresh_q.delete();
    if (m == dlp_pkg::MODE_RUN) begin
      n = int'(node_cnt_reg);
      if (n < 1) n = 1;
      if (n > NODES_MAX) n = NODES_MAX;
      foreach (blen[i]) begin
        blen[i] = 0;
        pred[i] = 0;
      end
      blen[0] = 1;
      head = 0;
      tail = 0;
      for (int i = 0; i < n; i++)
        if (in_deg[i] == 0) rq[tail++] = i;
      // Kahn order; cycle members never reach in-degree zero
      while (head < tail) begin
        cur = rq[head++];
        for (int e = 0; e < edge_cnt; e++) begin
          x = int'(edge_src[e]);
          // strictly longer only, so the earliest loaded predecessor wins ties
          if (edge_dst[e] == cur && blen[x] > 0 && blen[cur] < blen[x] + 1) begin
            blen[cur] = blen[x] + 1;
            pred[cur] = x + 1;
          end
        end
        for (int e = 0; e < edge_cnt; e++) begin
          y = int'(edge_dst[e]);
          if (edge_src[e] == cur && in_deg[y] > 0) begin
            in_deg[y]--;
            if (in_deg[y] == 0 && y < n && tail < NODES_MAX) rq[tail++] = y;
          end
        end
      end
      if (blen[n-1] == 0) begin
        add_fresh(dlp_pkg::KIND_NONE, '0, 1'b1);
      end else begin
        depth = 0;
        c = n;
        while (c != 0 && depth < NODES_MAX) begin
          stk[depth++] = c;
          c = pred[(c - 1) % NODES_MAX];
        end
        add_fresh(dlp_pkg::KIND_LEN, VW'(depth), 1'b0);
        while (depth > 0) begin
          depth--;
          add_fresh(dlp_pkg::KIND_NODE, VW'(stk[depth]), depth == 0);
        end
      end
      edge_cnt = 0;
      foreach (in_deg[i]) in_deg[i] = 0;
    end else if (a >= 1 && a <= NODES_MAX && b >= 1 && b <= NODES_MAX) begin
      // out-of-range nodes are silently ignored
      if (edge_cnt >= EDGES_MAX) begin
        add_fresh(dlp_pkg::KIND_FULL, '0, 1'b1);
      end else begin
        edge_src[edge_cnt] = 5'(a - 1);
        edge_dst[edge_cnt] = 5'(b - 1);
        edge_cnt++;
        in_deg[b-1]++;
      end
    end
  endtask

  // Offer one transfer, hold it until taken, then queue what it should cause.
  task automatic send_item(bit m, logic [VW-1:0] a, logic [VW-1:0] b,
                           bit typed, route_res_t tr);
    int gap;
    @(negedge clk_i);
    in_valid = 1'b1;
    mode = m;
    from_n = a;
    to_n = b;
    do @(posedge clk_i); while (in_stall);
    predict_route(m, a, b);
    if (typed) begin
      route_expect_q.insert(route_expect_q.size(), tr);
    end else begin
      foreach (fresh_q[i]) route_expect_q.insert(route_expect_q.size(), fresh_q[i]);
    end
    items_sent++;
    if (m == dlp_pkg::MODE_RUN) runs_sent++;
    // bursty sender: random gaps between random-length bursts
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = int'($urandom_range(0, 20));
      gap = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // node_count write once everything owed has come back and the block settled
  task automatic write_node_count(logic [VW-1:0] v);
    @(negedge clk_i);
    in_valid = 1'b0;
    while (route_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we = 1'b0;
    node_cnt_reg = v;
  endtask

  // Receiver stall: the stall pattern changes at random over time, plus one long hold-off
  // while the edge table overflows so the block backs up into its input.
  always @(negedge clk_i) begin
    if (!long_hold_done && hold_req) begin
      long_hold_done = 1'b1;
      hold_left = 500;
    end
    if (pat_cyc == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    pat_cyc = (pat_cyc + 1) % 50;
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = $urandom_range(0, 99) < stall_pct;
    end
  end

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk_i) begin
    route_res_t got, want;
    if (rst_ni && out_valid && !out_stall) begin
      got = '{kind, value, last};
      results_seen++;
      if (route_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result kind=%0d value=%0d last=%0d",
                   got.kind, got.value, got.last);
      end else begin
        want = route_expect_q.pop_front();
        if (got.kind == dlp_pkg::KIND_FULL) full_seen++;
        if (got.kind == dlp_pkg::KIND_NONE) none_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d exp kind=%0d value=%0d last=%0d, got %0d/%0d/%0d",
                     results_seen, want.kind, want.value, want.last,
                     got.kind, got.value, got.last);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results still owed", route_expect_q.size());
    $display("Regression FAIL");
    $finish;
  end

  dir_row_t dir_tab [25];

  initial begin
    int ne, n_edges, pick, graph_idx, wait_cyc;
    logic [VW-1:0] a, b, cfg_v;
    edge_cnt = 0;
    foreach (in_deg[i]) in_deg[i] = 0;
    node_cnt_reg = dlp_pkg::NODE_COUNT_RST;
    hold_left = 0;
    hold_req = 1'b0;
    pat_cyc = 0;
    stall_pct = 0;
    burst_left = 0;
    dir_tab = '{
      // nothing loaded: node 32 cannot be reached
      '{1'b0, dlp_pkg::MODE_RUN,  6'd0,  6'd0,  1'b1, '{dlp_pkg::KIND_NONE, 6'd0, 1'b1}},
      '{1'b1, dlp_pkg::MODE_LOAD, 6'd1,  6'd0,  1'b0, '0},
      '{1'b0, dlp_pkg::MODE_RUN,  6'd0,  6'd0,  1'b0, '0},   // single node route
      '{1'b1, dlp_pkg::MODE_LOAD, 6'd0,  6'd0,  1'b0, '0},   // zero acts as one
      '{1'b0, dlp_pkg::MODE_RUN,  6'd0,  6'd0,  1'b0, '0},
      '{1'b1, dlp_pkg::MODE_LOAD, 6'd4,  6'd0,  1'b0, '0},
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd1,  6'd2,  1'b0, '0},
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd2,  6'd4,  1'b0, '0},
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd1,  6'd3,  1'b0, '0},
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd3,  6'd4,  1'b0, '0},   // tie, first loaded wins
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd0,  6'd3,  1'b0, '0},   // bad nodes, ignored
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd2,  6'd33, 1'b0, '0},
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd63, 6'd63, 1'b0, '0},
      '{1'b0, dlp_pkg::MODE_RUN,  6'd0,  6'd0,  1'b0, '0},
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd1,  6'd2,  1'b0, '0},   // node 1 on a cycle
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd2,  6'd1,  1'b0, '0},
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd2,  6'd4,  1'b0, '0},
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd1,  6'd4,  1'b0, '0},
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd1,  6'd5,  1'b0, '0},   // edge past node_count
      '{1'b0, dlp_pkg::MODE_RUN,  6'd63, 6'd63, 1'b0, '0},
      '{1'b1, dlp_pkg::MODE_LOAD, 6'd63, 6'd0,  1'b0, '0},   // clamps to 32
      '{1'b0, dlp_pkg::MODE_RUN,  6'd0,  6'd0,  1'b1, '{dlp_pkg::KIND_NONE, 6'd0, 1'b1}},
      '{1'b1, dlp_pkg::MODE_LOAD, 6'd32, 6'd0,  1'b0, '0},
      '{1'b0, dlp_pkg::MODE_LOAD, 6'd1,  6'd32, 1'b0, '0},
      '{1'b0, dlp_pkg::MODE_RUN,  6'd0,  6'd0,  1'b0, '0}
    };
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg)
        write_node_count(dir_tab[i].a);
      else
        send_item(dir_tab[i].m, dir_tab[i].a, dir_tab[i].b, dir_tab[i].typed,
                  dir_tab[i].tr);
    end

    // Random graphs: mostly forward edges so routes exist, some noise.
    graph_idx = 0;
    while (items_sent < ITEM_GOAL) begin
      pick = int'($urandom_range(0, 9));
      if (graph_idx == 3) cfg_v = 6'd32;
      else if (pick == 0) cfg_v = VW'($urandom_range(0, 1));
      else if (pick == 1) cfg_v = VW'($urandom_range(32, 63));
      else cfg_v = VW'($urandom_range(2, 10));
      write_node_count(cfg_v);
      ne = cfg_v < 1 ? 1 : (cfg_v > NODES_MAX ? NODES_MAX : int'(cfg_v));
      // one graph overfills the edge table with valid edges only
      n_edges = graph_idx == 3 ? EDGES_MAX + 4
                               : int'($urandom_range(0, 2 * ne > 24 ? 24 : 2 * ne));
      for (int k = 0; k < n_edges; k++) begin
        pick = int'($urandom_range(0, 19));
        if (graph_idx == 3 && k == EDGES_MAX - 2) hold_req = 1'b1;
        if ((graph_idx == 3 || pick < 16) && ne >= 2) begin
          a = VW'($urandom_range(1, ne - 1));
          b = VW'($urandom_range(int'(a) + 1, ne));
        end else if (pick < 18) begin
          a = VW'($urandom_range(1, NODES_MAX));
          b = VW'($urandom_range(1, NODES_MAX));
        end else begin
          a = $urandom_range(0, 1) ? 6'd0 : VW'($urandom_range(33, 63));
          b = VW'($urandom_range(0, 63));
        end
        send_item(dlp_pkg::MODE_LOAD, a, b, 1'b0, '0);
      end
      send_item(dlp_pkg::MODE_RUN, VW'($urandom_range(0, 63)), VW'($urandom_range(0, 63)),
                1'b0, '0);
      graph_idx++;
    end

    @(negedge clk_i);
    in_valid = 1'b0;
    wait_cyc = 0;
    while (route_expect_q.size() != 0 && wait_cyc < 200000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Sent %0d transfers in %0d graphs, %0d searches; checked %0d results",
             items_sent, graph_idx, runs_sent, results_seen);
    $display("Unreachable reports %0d, table-full drops %0d, mismatches %0d",
             none_seen, full_seen, mismatches);
    if (mismatches == 0 && route_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
